>>> sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, cell layout, operation codes and the transfer types shared
// by the console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int CELL_W    = 16;
    localparam int COLOUR_W  = 8;
    localparam int CHAR_W    = 8;
    localparam int OP_W      = 2;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'h20;
    localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'h0A;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [CHAR_W-1:0]  character;
        logic [INDEX_W-1:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic                 scrolled;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [CELL_W-1:0] blank_cell(input logic [COLOUR_W-1:0] colour);
        return {colour, SPACE_CODE};
    endfunction

endpackage

>>> sv/text_console_writer.sv
`timescale 1ns / 1ps
// A put or newline goes straight to S_DONE for its result; a read passes through S_READ first.
// A clear walks the whole store once in S_FILL; a put that scrolls walks it in S_SCROLL.
// Throughput: one item at a time; the walker's single RAM write port sets the
// walk length, one cell per cycle.
// Reset (synchronous, active low) starts a clearing pass over every cell with stall
// high; colour writes are taken during it.
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell screen store with put, clear and read operations, cursor
// tracking and scroll-up past the last row.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::COLOUR_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcw_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tcw_pkg::t_out_item            o_out_data
);

    logic [tcw_pkg::COLOUR_W-1:0] r_text_colour;
    logic                         r_out_valid;
    tcw_pkg::t_out_item           r_out_data;

    logic                         w_res_valid;
    tcw_pkg::t_out_item           w_res;
    logic                         w_res_take;
    tcw_pkg::t_ram_req            w_ram;
    logic [tcw_pkg::CELL_W-1:0]   w_ram_rdata;

    // Colour register: to be written only while the block is quiet; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_colour <= tcw_pkg::RESET_COLOUR;
        end else if (i_cfg_we) begin
            r_text_colour <= i_cfg_data;
        end
    end

    // Screen store
    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_ram_rdata)
    );

    // Sequencer: cursor, decode and the clear/scroll walker
    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_colour    (r_text_colour),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take),
        .o_ram       (w_ram),
        .i_ram_rdata (w_ram_rdata)
    );

    // Output register: take a finished result whenever the slot is empty or
    // its contents leave in this cycle, so the sequencer is freed early
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled; load only on a new result
    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> sv/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer sequencer
// Cursor state, operation decode and the screen walker that clears or scrolls
// the store one cell per cycle; scroll source addresses share one adder with the cursor.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcw_pkg::COLOUR_W-1:0]  i_colour,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tcw_pkg::t_in_item             i_in_data,
    output logic                          o_res_valid,
    output tcw_pkg::t_out_item            o_res,
    input  logic                          i_res_take,
    output tcw_pkg::t_ram_req             o_ram,
    input  logic [tcw_pkg::CELL_W-1:0]    i_ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
    localparam logic [tcw_pkg::ADDR_W-1:0] BOTTOM_ROW =
        tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ADDR_W-1:0] ROW_STEP =
        tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
    localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
    localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);

    logic [2:0]                   r_state, n_state;
    logic [tcw_pkg::ADDR_W-1:0]   r_cnt, n_cnt;
    logic                         r_pend, n_pend;
    logic [tcw_pkg::ADDR_W-1:0]   r_pend_addr, n_pend_addr;
    logic                         r_init, n_init;
    logic                         r_rd_ok, n_rd_ok;
    logic [tcw_pkg::ROW_W-1:0]    r_row, n_row;
    logic [tcw_pkg::COL_W-1:0]    r_col, n_col;
    logic [tcw_pkg::ADDR_W-1:0]   r_base, n_base;
    logic [tcw_pkg::CELL_W-1:0]   r_value, n_value;
    logic                         r_scrolled, n_scrolled;

    logic [tcw_pkg::ADDR_W-1:0]   w_sum;
    logic                         w_in_range;

    // Shared adder: cursor cell address when idle, scroll source otherwise
    assign w_sum = (r_state == S_IDLE) ? r_base + tcw_pkg::ADDR_W'(r_col)
                                       : r_cnt + ROW_STEP;
    assign w_in_range = 32'(i_in_data.cell_index) < tcw_pkg::CELLS;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_init      = r_init;
        n_rd_ok     = r_rd_ok;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_value     = r_value;
        n_scrolled  = r_scrolled;
        o_ram       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_scrolled = 1'b0;
                    n_value    = '0;
                    case (i_in_data.operation)
                        tcw_pkg::OP_PUT: begin
                            if (i_in_data.character != tcw_pkg::NEWLINE_CODE) begin
                                o_ram.we    = 1'b1;
                                o_ram.waddr = w_sum;
                                o_ram.wdata = {i_colour, i_in_data.character};
                            end
                            if (i_in_data.character == tcw_pkg::NEWLINE_CODE ||
                                r_col == LAST_COL) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_scrolled = 1'b1;
                                    n_cnt      = '0;
                                    n_pend     = 1'b0;
                                    n_state    = S_SCROLL;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_base  = r_base + ROW_STEP;
                                    n_state = S_DONE;
                                end
                            end else begin
                                n_col   = r_col + 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        tcw_pkg::OP_CLEAR: begin
                            n_cnt   = '0;
                            n_init  = 1'b0;
                            n_row   = '0;
                            n_col   = '0;
                            n_base  = '0;
                            n_state = S_FILL;
                        end
                        tcw_pkg::OP_READ: begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = w_in_range ?
                                          tcw_pkg::ADDR_W'(i_in_data.cell_index) : '0;
                            n_rd_ok     = w_in_range;
                            n_state     = S_READ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_value = r_rd_ok ? i_ram_rdata : '0;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // write back the row-below cell fetched last cycle
                if (r_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pend_addr;
                    o_ram.wdata = i_ram_rdata;
                end
                if (r_cnt < BOTTOM_ROW) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = w_sum;
                    n_pend      = 1'b1;
                    n_pend_addr = r_cnt;
                    n_cnt       = r_cnt + 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_cnt;
                    o_ram.wdata = tcw_pkg::blank_cell(i_colour);
                    if (r_cnt == LAST_CELL) begin
                        n_state = S_DONE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FILL: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cnt;
                o_ram.wdata = r_init ? tcw_pkg::blank_cell(tcw_pkg::RESET_COLOUR)
                                     : tcw_pkg::blank_cell(i_colour);
                if (r_cnt == LAST_CELL) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
            r_init  <= 1'b1;
            r_row   <= '0;
            r_col   <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            r_init  <= n_init;
            r_row   <= n_row;
            r_col   <= n_col;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_rd_ok     <= n_rd_ok;
        r_value     <= n_value;
        r_scrolled  <= n_scrolled;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.cell_value = r_value;
        o_res.cursor_row = tcw_pkg::ROW_OUT_W'(r_row);
        o_res.cursor_col = tcw_pkg::COL_OUT_W'(r_col);
        o_res.scrolled   = r_scrolled;
    end

endmodule

>>> sv/tcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level properties of the console writer, attached by bind.
// ----------------------------------------------------------------------------
module tcw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input tcw_pkg::t_out_item            o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // Clearing pass follows reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input accepted straight after reset");

    // Reported cursor stays on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.cursor_row) < tcw_pkg::ROWS &&
                        32'(o_out_data.cursor_col) < tcw_pkg::COLUMNS)
        else $error("cursor off screen");

    // A scroll leaves the cursor at the start of the last row
    a_scroll_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.scrolled |->
            32'(o_out_data.cursor_row) == tcw_pkg::ROWS - 1 &&
            o_out_data.cursor_col == '0 && o_out_data.cell_value == '0)
        else $error("scroll left cursor misplaced");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Sends put, clear, read and unused-code commands through the valid/stall
// input channel and checks every report on the output channel against a
// cycle-free model of the screen store, the cursor and the scroll logic.
// The test runs a short directed pass, then randomised sessions of text
// lines, newline bursts, reads and clears under several text colours. Both
// channels idle at random, and the receiver holds off at times to back the
// block up.
// ----------------------------------------------------------------------------
module testbench;

    // The one operation code that the package leaves unnamed; it must be ignored.
    localparam logic [tcw_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles of receiver hold-off for the back-pressure stretches.
    localparam int unsigned LONG_HOLD = 300;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [tcw_pkg::COLOUR_W-1:0] cfg_data  = tcw_pkg::RESET_COLOUR;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    tcw_pkg::t_in_item            in_data   = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    tcw_pkg::t_out_item           out_data;

    // Commands waiting for the driver, and reports the block still owes us.
    tcw_pkg::t_in_item  console_cmds[$];
    tcw_pkg::t_out_item pending_reports[$];

    // Model of the block: screen image, cursor and current colour.
    logic [tcw_pkg::CELL_W-1:0]   screen_img [tcw_pkg::CELLS];
    int unsigned                  cur_row;
    int unsigned                  cur_col;
    logic [tcw_pkg::COLOUR_W-1:0] colour_reg;

    // Handshake flags, set at the rising edge and read at the falling edge.
    bit cmd_taken    = 1'b0;
    bit report_taken = 1'b0;

    // Driver and receiver state.
    bit                offering  = 1'b0;
    bit                tx_calm   = 1'b0;
    bit                rx_calm   = 1'b0;
    int unsigned       tx_gap    = 0;
    int unsigned       rx_wait   = 0;
    int unsigned       hold_left = 0;
    tcw_pkg::t_in_item cur_cmd   = '0;

    int unsigned mismatches   = 0;
    int unsigned reports_seen = 0;

    text_console_writer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // 4 ns clock: low half first, then high half.
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Screen model
    // ------------------------------------------------------------------------

    // Fill every cell with a space in the current colour.
    function automatic void blank_screen();
        for (int i = 0; i < tcw_pkg::CELLS; i++) begin
            screen_img[i] = {colour_reg, tcw_pkg::SPACE_CODE};
        end
    endfunction

    // Drop to column 0 of the next row; past the last row, shift the image
    // up one row, blank the bottom row and pin the cursor there.
    function automatic bit advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row >= tcw_pkg::ROWS) begin
            for (int i = 0; i + tcw_pkg::COLUMNS < tcw_pkg::CELLS; i++) begin
                screen_img[i] = screen_img[i + tcw_pkg::COLUMNS];
            end
            for (int i = tcw_pkg::CELLS - tcw_pkg::COLUMNS; i < tcw_pkg::CELLS; i++) begin
                screen_img[i] = {colour_reg, tcw_pkg::SPACE_CODE};
            end
            cur_row = tcw_pkg::ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one command to the model and return the report it should cause.
    function automatic tcw_pkg::t_out_item console_apply(input tcw_pkg::t_in_item cmd);
        tcw_pkg::t_out_item rep;
        int unsigned        pos;
        rep = '0;
        case (cmd.operation)
            tcw_pkg::OP_PUT: begin
                if (cmd.character == tcw_pkg::NEWLINE_CODE) begin
                    // A newline moves the cursor only; no cell is touched.
                    rep.scrolled = advance_row();
                end else begin
                    pos = cur_row * tcw_pkg::COLUMNS + cur_col;
                    if (pos < tcw_pkg::CELLS) begin
                        screen_img[pos] = {colour_reg, cmd.character};
                    end
                    cur_col++;
                    if (cur_col >= tcw_pkg::COLUMNS) begin
                        rep.scrolled = advance_row();
                    end
                end
            end
            tcw_pkg::OP_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            tcw_pkg::OP_READ: begin
                // Reads past the end of the store report zero.
                if (cmd.cell_index < tcw_pkg::CELLS) begin
                    rep.cell_value = screen_img[cmd.cell_index];
                end
            end
            default: begin
                // Unused code: leave everything as it is.
            end
        endcase
        rep.cursor_row = tcw_pkg::ROW_OUT_W'(cur_row);
        rep.cursor_col = tcw_pkg::COL_OUT_W'(cur_col);
        return rep;
    endfunction

    initial begin
        colour_reg = tcw_pkg::RESET_COLOUR;
        cur_row    = 0;
        cur_col    = 0;
        blank_screen();
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void add_cmd(input logic [tcw_pkg::OP_W-1:0] op,
                                    input logic [tcw_pkg::CHAR_W-1:0] ch,
                                    input logic [tcw_pkg::INDEX_W-1:0] idx);
        tcw_pkg::t_in_item cmd;
        cmd.operation  = op;
        cmd.character  = ch;
        cmd.cell_index = idx;
        console_cmds.push_back(cmd);
    endfunction

    // Hold until every command has been sent and every report has come back.
    task automatic wait_idle();
        while (console_cmds.size() != 0 || offering || pending_reports.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Write the colour register for one cycle and track it in the model.
    task automatic set_colour(input logic [tcw_pkg::COLOUR_W-1:0] colour);
        @(negedge clk);
        cfg_we     <= 1'b1;
        cfg_data   <= colour;
        colour_reg  = colour;
        @(negedge clk);
        cfg_we     <= 1'b0;
    endtask

    // Queue a session of console traffic: mostly lines of text and newline
    // runs, so the cursor wraps and the screen scrolls, with reads spread
    // over the store and an occasional clear or unused code as noise.
    task automatic queue_session(input int unsigned target);
        int unsigned made;
        int unsigned len;
        int unsigned pick;
        int unsigned where;
        made = 0;
        while (made < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // A line of text: mostly short, sometimes past a full row.
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 95)
                                                  : $urandom_range(0, 8);
                repeat (len) begin
                    add_cmd(tcw_pkg::OP_PUT, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                            tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
                end
                made += len;
                if ($urandom_range(0, 3) != 0) begin
                    add_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE,
                            tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
                    made++;
                end
            end else if (pick < 65) begin
                // A run of newlines to push the cursor to the bottom and beyond.
                len = $urandom_range(1, 30);
                repeat (len) begin
                    add_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE,
                            tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
                end
                made += len;
            end else if (pick < 92) begin
                // A few reads, biased towards the bottom rows where text lands.
                len = $urandom_range(1, 4);
                repeat (len) begin
                    where = $urandom_range(0, 9);
                    add_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                            (where < 4) ? tcw_pkg::INDEX_W'($urandom_range(
                                              tcw_pkg::CELLS - 5 * tcw_pkg::COLUMNS,
                                              tcw_pkg::CELLS - 1))
                          : (where < 8) ? tcw_pkg::INDEX_W'($urandom_range(
                                              0, tcw_pkg::CELLS - 1))
                          :               tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
                end
                made += len;
            end else if (pick < 97) begin
                add_cmd(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                        tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
                made++;
            end else begin
                // Ignored by the block, so it does not count towards the session.
                add_cmd(OP_UNUSED, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                        tcw_pkg::INDEX_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        tcw_pkg::t_out_item want;
        cmd_taken    = 1'b0;
        report_taken = 1'b0;
        if (rst_n) begin
            // Check a report transfer against the oldest outstanding one.
            if (out_valid === 1'b1 && out_stall == 1'b0) begin
                report_taken = 1'b1;
                reports_seen++;
                if (pending_reports.size() == 0) begin
                    $error("report arrived with no command outstanding");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    if (out_data.cell_value !== want.cell_value) begin
                        $error("cell_value expected %h actual %h",
                               want.cell_value, out_data.cell_value);
                        mismatches++;
                    end
                    if (out_data.cursor_row !== want.cursor_row) begin
                        $error("cursor_row expected %0d actual %0d",
                               want.cursor_row, out_data.cursor_row);
                        mismatches++;
                    end
                    if (out_data.cursor_col !== want.cursor_col) begin
                        $error("cursor_col expected %0d actual %0d",
                               want.cursor_col, out_data.cursor_col);
                        mismatches++;
                    end
                    if (out_data.scrolled !== want.scrolled) begin
                        $error("scrolled expected %0b actual %0b",
                               want.scrolled, out_data.scrolled);
                        mismatches++;
                    end
                end
            end
            // Predict the report for a command transfer as it is taken.
            if (in_valid && in_stall === 1'b0) begin
                cmd_taken = 1'b1;
                pending_reports.push_back(console_apply(in_data));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: present commands at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            // Drop the command just taken and draw the gap before the next one;
            // now and then switch between gappy and back-to-back stretches.
            if (cmd_taken) begin
                offering = 1'b0;
                if ($urandom_range(0, 31) == 0) begin
                    tx_calm = !tx_calm;
                end
                tx_gap = tx_calm ? 0 : $urandom_range(0, 4);
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (console_cmds.size() > 0) begin
                    cur_cmd  = console_cmds.pop_front();
                    offering = 1'b1;
                end
            end
            // Hold the payload steady for as long as it is offered.
            in_valid <= offering;
            in_data  <= cur_cmd;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: drive the output stall at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk) begin : receiver
        bit stall_now;
        if (rst_n) begin
            if (report_taken) begin
                if ($urandom_range(0, 31) == 0) begin
                    rx_calm = !rx_calm;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 4);
                // Every 250 reports, hold off long enough to back up the input.
                if (reports_seen % 250 == 120) begin
                    hold_left = LONG_HOLD;
                end
            end
            stall_now = (hold_left > 0) || (rx_wait > 0);
            if (hold_left > 0) begin
                hold_left--;
            end
            if (rx_wait > 0) begin
                rx_wait--;
            end
            out_stall <= stall_now;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset low at the start; the block then runs its clearing pass
        // with the input stalled, which the driver simply waits out.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass under the reset colour.
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);             // reset contents
        add_cmd(tcw_pkg::OP_READ, 8'hFF, 11'd1999);          // last cell
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd2000);          // just past the store
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd2047);          // top of the index range
        add_cmd(OP_UNUSED, 8'hFF, 11'd2047);                 // unused code, all ones
        add_cmd(tcw_pkg::OP_PUT, 8'h00, 11'd0);              // lowest character
        add_cmd(tcw_pkg::OP_PUT, 8'hFF, 11'd2047);           // highest character
        add_cmd(tcw_pkg::OP_PUT, 8'h41, 11'd0);
        add_cmd(tcw_pkg::OP_PUT, tcw_pkg::NEWLINE_CODE, 11'd0); // newline writes no cell
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd1);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd3);             // where the newline stood
        add_cmd(tcw_pkg::OP_PUT, 8'h42, 11'd0);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd80);
        add_cmd(tcw_pkg::OP_CLEAR, 8'hFF, 11'd2047);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd80);
        add_cmd(tcw_pkg::OP_READ, 8'h00, 11'd0);
        add_cmd(OP_UNUSED, 8'h00, 11'd0);                    // unused code, all zeros
        add_cmd(tcw_pkg::OP_PUT, 8'h7E, 11'd0);
        wait_idle();

        // Random sessions, each under its own colour.
        set_colour(8'hFF);
        queue_session(200);
        wait_idle();

        set_colour(8'h00);
        queue_session(200);
        wait_idle();

        set_colour(tcw_pkg::COLOUR_W'($urandom_range(1, 254)));
        queue_session(200);
        wait_idle();

        // Give any stray late report a chance to show up.
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
